FILE: rtl/core/mm4_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm4_pkg
// Shared types and widths for the 4x4 fixed-point matrix multiplier.
// ----------------------------------------------------------------------------
package mm4_pkg;

    localparam int DIM    = 4;
    localparam int WORD_W = 32;
    localparam int PROD_W = 2 * WORD_W;
    localparam int PAIR_W = PROD_W + 1;
    localparam int SUM_W  = PROD_W + 2;
    localparam int IDX_W  = $clog2(DIM);

    localparam logic [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    localparam logic KIND_LOAD     = 1'b0;
    localparam logic KIND_MULTIPLY = 1'b1;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic [IDX_W-1:0]         idx_t;

    // stage advance enables shared by all lanes
    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
    } pipe_ctrl_t;

endpackage

FILE: rtl/core/mm4_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm4_lane
// One result row: four products, a two-level registered adder tree, then an
// arithmetic shift and saturation to 32 bits.
// ----------------------------------------------------------------------------
module mm4_lane #(
    parameter int FRAC_BITS = 16
) (
    input  logic                clk,
    input  mm4_pkg::pipe_ctrl_t ctrl,
    input  mm4_pkg::word_t      a [mm4_pkg::DIM],
    input  mm4_pkg::word_t      b [mm4_pkg::DIM],
    output mm4_pkg::word_t      result,
    output logic                sat
);

    localparam int NPAIR = mm4_pkg::DIM / 2;

    logic signed [mm4_pkg::PROD_W-1:0] prod_reg [mm4_pkg::DIM];
    logic signed [mm4_pkg::PAIR_W-1:0] pair_reg [NPAIR];
    logic signed [mm4_pkg::SUM_W-1:0]  sum_reg;
    logic signed [mm4_pkg::SUM_W-1:0]  sum_next;
    logic signed [mm4_pkg::SUM_W-1:0]  shifted;
    logic [mm4_pkg::SUM_W-mm4_pkg::WORD_W:0] top_bits;
    logic                              fits;

    always_ff @(posedge clk)
    begin
        if (ctrl.en1)
        begin
            for (int k = 0; k < mm4_pkg::DIM; k++)
            begin
                prod_reg[k] <= mm4_pkg::PROD_W'(a[k]) * mm4_pkg::PROD_W'(b[k]);
            end
        end
        if (ctrl.en2)
        begin
            for (int p = 0; p < NPAIR; p++)
            begin
                pair_reg[p] <= mm4_pkg::PAIR_W'(prod_reg[2*p])
                             + mm4_pkg::PAIR_W'(prod_reg[2*p+1]);
            end
        end
        if (ctrl.en3)
        begin
            sum_reg <= sum_next;
        end
    end

    always_comb
    begin
        sum_next = '0;
        for (int p = 0; p < NPAIR; p++)
        begin
            sum_next = sum_next + mm4_pkg::SUM_W'(pair_reg[p]);
        end
    end

    // floor shift, then clip when the upper bits are not a pure sign extension
    assign shifted  = sum_reg >>> FRAC_BITS;
    assign top_bits = shifted[mm4_pkg::SUM_W-1:mm4_pkg::WORD_W-1];
    assign fits     = (&top_bits) || !(|top_bits);
    assign sat      = !fits;

    always_comb
    begin
        if (fits)
        begin
            result = shifted[mm4_pkg::WORD_W-1:0];
        end
        else if (shifted[mm4_pkg::SUM_W-1])
        begin
            result = mm4_pkg::WORD_MIN;
        end
        else
        begin
            result = mm4_pkg::WORD_MAX;
        end
    end

endmodule

FILE: rtl/core/mm4_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm4_merge
// Gathers the lane results into the output register and folds the lane
// saturation flags into one.
// ----------------------------------------------------------------------------
module mm4_merge (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           lane_valid,
    input  mm4_pkg::idx_t  lane_col,
    input  mm4_pkg::word_t lane_val [mm4_pkg::DIM],
    input  logic           lane_sat [mm4_pkg::DIM],
    output logic           take,
    output logic           out_valid,
    input  logic           out_ready,
    output mm4_pkg::idx_t  result_column,
    output mm4_pkg::word_t merged [mm4_pkg::DIM],
    output logic           saturated
);

    logic          valid_reg;
    logic          sat_next;
    logic          sat_reg;
    mm4_pkg::idx_t col_reg;
    mm4_pkg::word_t val_reg [mm4_pkg::DIM];

    assign take = !valid_reg || out_ready;

    always_comb
    begin
        sat_next = 1'b0;
        for (int r = 0; r < mm4_pkg::DIM; r++)
        begin
            sat_next = sat_next | lane_sat[r];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= lane_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && lane_valid)
        begin
            col_reg <= lane_col;
            sat_reg <= sat_next;
            for (int r = 0; r < mm4_pkg::DIM; r++)
            begin
                val_reg[r] <= lane_val[r];
            end
        end
    end

    assign out_valid     = valid_reg;
    assign result_column = col_reg;
    assign saturated     = sat_reg;

    always_comb
    begin
        for (int r = 0; r < mm4_pkg::DIM; r++)
        begin
            merged[r] = val_reg[r];
        end
    end

endmodule

FILE: rtl/core/matrix_multiply_4x4.sv
// a multiply result passes the product, pair, sum and output registers
// throughput: one per cycle unless stalled, loads and multiplies mixed freely;
// the three lane stages and the output register each move when the next is free
// a load takes effect for a multiply accepted in the very next cycle
// reset clears the stage valid bits and the output valid bit; the stored
// left matrix is not cleared and holds nothing until its columns are loaded
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_multiply_4x4
// Column-major 4x4 Q16.16 matrix product: stores the left matrix, then maps
// each right-matrix column to a result column through four row lanes.
// ----------------------------------------------------------------------------
module matrix_multiply_4x4 #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 kind,
    input  logic [1:0]           column_index,
    input  logic signed [31:0]   elem_0,
    input  logic signed [31:0]   elem_1,
    input  logic signed [31:0]   elem_2,
    input  logic signed [31:0]   elem_3,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           result_column,
    output logic signed [31:0]   out_0,
    output logic signed [31:0]   out_1,
    output logic signed [31:0]   out_2,
    output logic signed [31:0]   out_3,
    output logic                 saturated
);

    mm4_pkg::word_t      left_reg [mm4_pkg::DIM][mm4_pkg::DIM];  // [column][row]
    mm4_pkg::word_t      col_in [mm4_pkg::DIM];
    mm4_pkg::word_t      lane_a [mm4_pkg::DIM][mm4_pkg::DIM];    // [row][k]
    mm4_pkg::word_t      lane_val [mm4_pkg::DIM];
    mm4_pkg::word_t      merged [mm4_pkg::DIM];
    logic                lane_sat [mm4_pkg::DIM];
    mm4_pkg::pipe_ctrl_t ctrl;
    logic                take;
    logic                accept;
    logic                v1_reg;
    logic                v2_reg;
    logic                v3_reg;
    mm4_pkg::idx_t       c1_reg;
    mm4_pkg::idx_t       c2_reg;
    mm4_pkg::idx_t       c3_reg;

    assign col_in[0] = elem_0;
    assign col_in[1] = elem_1;
    assign col_in[2] = elem_2;
    assign col_in[3] = elem_3;

    // each stage moves on when the one after it is empty or moving
    assign ctrl.en3 = !v3_reg || take;
    assign ctrl.en2 = !v2_reg || ctrl.en3;
    assign ctrl.en1 = !v1_reg || ctrl.en2;
    assign in_ready = ctrl.en1;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk)
    begin
        if (accept && kind == mm4_pkg::KIND_LOAD)
        begin
            for (int r = 0; r < mm4_pkg::DIM; r++)
            begin
                left_reg[column_index][r] <= col_in[r];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.en1)
            begin
                v1_reg <= accept && kind == mm4_pkg::KIND_MULTIPLY;
            end
            if (ctrl.en2)
            begin
                v2_reg <= v1_reg;
            end
            if (ctrl.en3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en1)
        begin
            c1_reg <= column_index;
        end
        if (ctrl.en2)
        begin
            c2_reg <= c1_reg;
        end
        if (ctrl.en3)
        begin
            c3_reg <= c2_reg;
        end
    end

    always_comb
    begin
        for (int r = 0; r < mm4_pkg::DIM; r++)
        begin
            for (int k = 0; k < mm4_pkg::DIM; k++)
            begin
                lane_a[r][k] = left_reg[k][r];
            end
        end
    end

    for (genvar r = 0; r < mm4_pkg::DIM; r++)
    begin : g_lane
        mm4_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .clk    (clk),
            .ctrl   (ctrl),
            .a      (lane_a[r]),
            .b      (col_in),
            .result (lane_val[r]),
            .sat    (lane_sat[r])
        );
    end

    mm4_merge u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .lane_valid    (v3_reg),
        .lane_col      (c3_reg),
        .lane_val      (lane_val),
        .lane_sat      (lane_sat),
        .take          (take),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .result_column (result_column),
        .merged        (merged),
        .saturated     (saturated)
    );

    assign out_0 = merged[0];
    assign out_1 = merged[1];
    assign out_2 = merged[2];
    assign out_3 = merged[3];

`ifndef SYNTHESIS
    a_mul_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && kind == mm4_pkg::KIND_MULTIPLY) |=> v1_reg)
        else $error("multiply transaction did not enter the lanes");

    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && kind == mm4_pkg::KIND_LOAD) |=> !v1_reg)
        else $error("load transaction entered the lanes");

    a_out_from_lanes: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(v3_reg))
        else $error("result appeared without a finished lane stage");

    a_sat_clipped: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && saturated) |->
            (out_0 == mm4_pkg::WORD_MAX || out_0 == mm4_pkg::WORD_MIN ||
             out_1 == mm4_pkg::WORD_MAX || out_1 == mm4_pkg::WORD_MIN ||
             out_2 == mm4_pkg::WORD_MAX || out_2 == mm4_pkg::WORD_MIN ||
             out_3 == mm4_pkg::WORD_MAX || out_3 == mm4_pkg::WORD_MIN))
        else $error("saturation flagged but no element clipped");
`endif

endmodule

FILE: tb/matrix_multiply_4x4_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_multiply_4x4_tb
// Loads left-matrix columns and streams right-matrix columns through the
// multiplier. Every result column is checked against an in-bench predictor
// that uses exact wide sums, a floor shift and 32-bit saturation. A short
// directed set covers identity, rounding and saturation. Random traffic
// follows in three phases, idle only in the first two, each fully drained.
// ----------------------------------------------------------------------------
module matrix_multiply_4x4_tb;

    localparam int FRAC = 16;
    localparam int PHASE_ITEMS = 650;
    localparam mm4_pkg::word_t ONE = 32'sh0001_0000;
    localparam logic signed [67:0] CLIP_HI = 68'sh7FFF_FFFF;
    localparam logic signed [67:0] CLIP_LO = -68'sh8000_0000;

    typedef struct {
        logic           kind;
        mm4_pkg::idx_t  col;
        mm4_pkg::word_t e [mm4_pkg::DIM];
    } column_item_t;

    typedef struct {
        mm4_pkg::idx_t  col;
        mm4_pkg::word_t o [mm4_pkg::DIM];
        logic           sat;
    } column_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic           in_valid = 1'b0;
    logic           in_ready;
    logic           kind = mm4_pkg::KIND_LOAD;
    logic [1:0]     column_index = '0;
    mm4_pkg::word_t elem_0 = '0;
    mm4_pkg::word_t elem_1 = '0;
    mm4_pkg::word_t elem_2 = '0;
    mm4_pkg::word_t elem_3 = '0;
    logic           out_valid;
    logic           out_ready = 1'b0;
    logic [1:0]     result_column;
    mm4_pkg::word_t out_0;
    mm4_pkg::word_t out_1;
    mm4_pkg::word_t out_2;
    mm4_pkg::word_t out_3;
    logic           saturated;

    column_item_t   column_queue [$];
    column_result_t expected_columns [$];
    mm4_pkg::word_t left_copy [mm4_pkg::DIM][mm4_pkg::DIM];   // [column][row]
    int             tx_idle_pct = 0;
    int             rx_idle_pct = 0;
    int             mismatches = 0;

    matrix_multiply_4x4 #(
        .FRAC_BITS     (FRAC)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .column_index  (column_index),
        .elem_0        (elem_0),
        .elem_1        (elem_1),
        .elem_2        (elem_2),
        .elem_3        (elem_3),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .result_column (result_column),
        .out_0         (out_0),
        .out_1         (out_1),
        .out_2         (out_2),
        .out_3         (out_3),
        .saturated     (saturated)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("FAIL");
        $finish;
    end

    // exact sum of products, floor shift, clip to 32 bits
    function automatic column_result_t product_column(mm4_pkg::idx_t col,
                                                      mm4_pkg::word_t b [mm4_pkg::DIM]);
        column_result_t res;
        logic signed [67:0] acc;
        logic signed [67:0] shifted;
        longint prod;
        res.col = col;
        res.sat = 1'b0;
        for (int r = 0; r < mm4_pkg::DIM; r++)
        begin
            acc = '0;
            for (int k = 0; k < mm4_pkg::DIM; k++)
            begin
                prod = longint'(left_copy[k][r]) * longint'(b[k]);
                acc = acc + prod;
            end
            shifted = acc >>> FRAC;
            if (shifted > CLIP_HI)
            begin
                res.o[r] = mm4_pkg::WORD_MAX;
                res.sat = 1'b1;
            end
            else if (shifted < CLIP_LO)
            begin
                res.o[r] = mm4_pkg::WORD_MIN;
                res.sat = 1'b1;
            end
            else
            begin
                res.o[r] = shifted[31:0];
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        $display("%0t ns mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic compare_word(string name, mm4_pkg::word_t got, mm4_pkg::word_t want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    function automatic column_item_t make_item(logic k, mm4_pkg::idx_t col,
                                               mm4_pkg::word_t a, mm4_pkg::word_t b,
                                               mm4_pkg::word_t c, mm4_pkg::word_t d);
        column_item_t it;
        it.kind = k;
        it.col = col;
        it.e[0] = a;
        it.e[1] = b;
        it.e[2] = c;
        it.e[3] = d;
        return it;
    endfunction

    function automatic mm4_pkg::word_t rand_elem();
        int unsigned pick;
        pick = $urandom_range(9);
        if (pick <= 4)
            return mm4_pkg::word_t'($urandom);
        if (pick <= 7)
            return mm4_pkg::word_t'(int'($urandom_range(524288)) - 262144);
        case ($urandom_range(5))
            0: return mm4_pkg::WORD_MAX;
            1: return mm4_pkg::WORD_MIN;
            2: return '0;
            3: return -32'sd1;
            4: return ONE;
            default: return -ONE;
        endcase
    endfunction

    task automatic queue_diag(mm4_pkg::word_t v);
        mm4_pkg::word_t e [mm4_pkg::DIM];
        for (int c = 0; c < mm4_pkg::DIM; c++)
        begin
            for (int r = 0; r < mm4_pkg::DIM; r++)
                e[r] = (r == c) ? v : '0;
            column_queue.push_back(make_item(mm4_pkg::KIND_LOAD, mm4_pkg::idx_t'(c),
                                             e[0], e[1], e[2], e[3]));
        end
    endtask

    task automatic queue_fill(mm4_pkg::word_t v);
        for (int c = 0; c < mm4_pkg::DIM; c++)
            column_queue.push_back(make_item(mm4_pkg::KIND_LOAD, mm4_pkg::idx_t'(c),
                                             v, v, v, v));
    endtask

    task automatic queue_random(int count);
        column_item_t it;
        for (int i = 0; i < count; i++)
        begin
            it.kind = ($urandom_range(99) < 30) ? mm4_pkg::KIND_LOAD : mm4_pkg::KIND_MULTIPLY;
            it.col = mm4_pkg::idx_t'($urandom_range(mm4_pkg::DIM - 1));
            for (int r = 0; r < mm4_pkg::DIM; r++)
                it.e[r] = rand_elem();
            column_queue.push_back(it);
        end
    endtask

    // the test waits until the block has nothing left in flight
    task automatic wait_drained();
        while (column_queue.size() != 0 || in_valid || expected_columns.size() != 0)
            @(negedge clk);
    endtask

    // driver
    always @(posedge clk)
    begin
        column_item_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_ready)
        begin
            if (column_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct)
            begin
                nxt = column_queue.pop_front();
                in_valid     <= 1'b1;
                kind         <= nxt.kind;
                column_index <= nxt.col;
                elem_0       <= nxt.e[0];
                elem_1       <= nxt.e[1];
                elem_2       <= nxt.e[2];
                elem_3       <= nxt.e[3];
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        out_ready <= rst_n && ($urandom_range(99) >= rx_idle_pct);
    end

    // monitor and predictor
    always @(posedge clk)
    begin
        column_result_t want;
        mm4_pkg::word_t b [mm4_pkg::DIM];
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_columns.size() == 0)
                begin
                    report_mismatch("result transaction with none expected");
                end
                else
                begin
                    want = expected_columns.pop_front();
                    if (result_column !== want.col)
                        report_mismatch($sformatf("result_column got %0d want %0d",
                                                  result_column, want.col));
                    compare_word("out_0", out_0, want.o[0]);
                    compare_word("out_1", out_1, want.o[1]);
                    compare_word("out_2", out_2, want.o[2]);
                    compare_word("out_3", out_3, want.o[3]);
                    if (saturated !== want.sat)
                        report_mismatch($sformatf("saturated got %b want %b",
                                                  saturated, want.sat));
                end
            end
            if (in_valid && in_ready)
            begin
                b[0] = elem_0;
                b[1] = elem_1;
                b[2] = elem_2;
                b[3] = elem_3;
                if (kind == mm4_pkg::KIND_LOAD)
                begin
                    for (int r = 0; r < mm4_pkg::DIM; r++)
                        left_copy[column_index][r] = b[r];
                end
                else
                begin
                    expected_columns.push_back(product_column(column_index, b));
                end
            end
        end
    end

    initial
    begin
        tx_idle_pct = 6;
        rx_idle_pct = 60;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // identity passes values through, extremes included
        queue_diag(ONE);
        column_queue.push_back(make_item(mm4_pkg::KIND_MULTIPLY, 2'd0, mm4_pkg::WORD_MAX,
                                         mm4_pkg::WORD_MIN, '0, -32'sd1));
        // raw diagonal of one: shift floors toward minus infinity
        queue_diag(32'sd1);
        column_queue.push_back(make_item(mm4_pkg::KIND_MULTIPLY, 2'd2, -32'sd1, -ONE,
                                         32'sh0000_FFFF, 32'sh0001_FFFF));
        // saturation in both directions
        queue_fill(mm4_pkg::WORD_MAX);
        column_queue.push_back(make_item(mm4_pkg::KIND_MULTIPLY, 2'd3,
                                         mm4_pkg::WORD_MAX, mm4_pkg::WORD_MAX,
                                         mm4_pkg::WORD_MAX, mm4_pkg::WORD_MAX));
        column_queue.push_back(make_item(mm4_pkg::KIND_MULTIPLY, 2'd0,
                                         mm4_pkg::WORD_MIN, mm4_pkg::WORD_MIN,
                                         mm4_pkg::WORD_MIN, mm4_pkg::WORD_MIN));
        queue_fill(mm4_pkg::WORD_MIN);
        column_queue.push_back(make_item(mm4_pkg::KIND_MULTIPLY, 2'd1,
                                         mm4_pkg::WORD_MIN, mm4_pkg::WORD_MIN,
                                         mm4_pkg::WORD_MIN, mm4_pkg::WORD_MIN));
        // just inside and just outside the 32-bit range
        queue_diag(32'sh0002_0000);
        column_queue.push_back(make_item(mm4_pkg::KIND_MULTIPLY, 2'd2, 32'sh4000_0000,
                                         32'shC000_0000, 32'sh3FFF_FFFF, 32'shBFFF_FFFF));

        queue_random(PHASE_ITEMS);
        wait_drained();

        tx_idle_pct = 60;
        rx_idle_pct = 6;
        queue_random(PHASE_ITEMS);
        wait_drained();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        queue_random(PHASE_ITEMS);
        wait_drained();

        repeat (8) @(negedge clk);
        if (mismatches == 0 && expected_columns.size() == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
